@@ design/swpr_pkg.sv @@
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types and constants for the sync word packet receiver.
// ----------------------------------------------------------------------------
package swpr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned RETRY_W  = 4;
	localparam int unsigned SYNC_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0]   MAX_LENGTH_RST     = 8'd255;
	localparam logic [PERIOD_W-1:0] TIMEOUT_PERIOD_RST = 16'd256;
	localparam logic [RETRY_W-1:0]  RETRY_COUNT_RST    = 4'd3;
	localparam logic [SYNC_W-1:0]   SYNC_WORD_RST      = 16'hC0DE;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_LENGTH     = 2'd0,
		CFG_TIMEOUT_PERIOD = 2'd1,
		CFG_RETRY_COUNT    = 2'd2,
		CFG_SYNC_WORD      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_BYTE  = 3'd1,
		EV_LAST  = 3'd2,
		EV_EMPTY = 3'd3,
		EV_NOPKT = 3'd4,
		EV_DTMO  = 3'd5
	} event_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   max_length;
		logic [PERIOD_W-1:0] timeout_period;
		logic [RETRY_W-1:0]  retry_count;
		logic [SYNC_W-1:0]   sync_word;
	} cfg_t;

	typedef struct packed {
		event_t            event_res;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] length;
	} res_t;

endpackage

@@ design/sync_word_packet_receiver.sv @@
// An accepted request is held in the input register, then moves on into the result
// register once it is free; throughput one request per cycle when not stalled.
// The result register frees itself when taken, so both sides stream freely.
// Reset clears the deframer to idle and loads the register defaults
// (max length 255, timeout 256 ticks, 3 retries, sync word C0 DE).
// ----------------------------------------------------------------------------
// sync_word_packet_receiver
// Sync word and length prefixed packet deframer with timeout and retries.
// ----------------------------------------------------------------------------
module sync_word_packet_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
	input  logic [1:0]                        s_tuser,   // [1:0] mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // [7:0] data, [15:8] length
	output logic [2:0]                        m_tuser,   // [2:0] event_res
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	swpr_pkg::cfg_t             cfg_q;
	logic                       valid_s1;
	logic [1:0]                 mode_s1;
	logic [swpr_pkg::BYTE_W-1:0] byte_s1;
	logic                       out_free;
	logic                       step;
	swpr_pkg::res_t             res;
	swpr_pkg::res_t             res_q;
	logic                       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length     <= swpr_pkg::MAX_LENGTH_RST;
			cfg_q.timeout_period <= swpr_pkg::TIMEOUT_PERIOD_RST;
			cfg_q.retry_count    <= swpr_pkg::RETRY_COUNT_RST;
			cfg_q.sync_word      <= swpr_pkg::SYNC_WORD_RST;
		end else if (cfg_valid) begin
			unique case (swpr_pkg::cfg_idx_t'(cfg_index))
				swpr_pkg::CFG_MAX_LENGTH:
					cfg_q.max_length <= cfg_data[swpr_pkg::BYTE_W-1:0];
				swpr_pkg::CFG_TIMEOUT_PERIOD:
					cfg_q.timeout_period <= cfg_data[swpr_pkg::PERIOD_W-1:0];
				swpr_pkg::CFG_RETRY_COUNT:
					cfg_q.retry_count <= cfg_data[swpr_pkg::RETRY_W-1:0];
				swpr_pkg::CFG_SYNC_WORD:
					cfg_q.sync_word <= cfg_data[swpr_pkg::SYNC_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 advances whenever the result register is empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	swpr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.mode    (mode_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.length, res_q.data};
	assign m_tuser  = res_q.event_res;

endmodule

@@ design/swpr_core.sv @@
// ----------------------------------------------------------------------------
// swpr_core
// Deframer state and next-state logic; one request handled per step.
// ----------------------------------------------------------------------------
module swpr_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [1:0]                          mode,
	input  logic [swpr_pkg::BYTE_W-1:0]         rx_byte,
	input  swpr_pkg::cfg_t                      cfg,
	output swpr_pkg::res_t                      res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HUNT  = 3'd1,
		PH_SYNC2 = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t                              phase_q, phase_d;
	logic [swpr_pkg::RETRY_W-1:0]        retries_q, retries_d;
	logic [swpr_pkg::PERIOD_W-1:0]       ticks_q, ticks_d, ticks_inc;
	logic [swpr_pkg::BYTE_W-1:0]         remain_q, remain_d, remain_dec;
	logic [swpr_pkg::BYTE_W-1:0]         pkt_len_q, pkt_len_d;
	logic                                timeout;

	assign ticks_inc  = ticks_q + 1'b1;
	assign remain_dec = remain_q - 1'b1;
	assign timeout    = (ticks_inc == cfg.timeout_period);

	always_comb begin
		phase_d       = phase_q;
		retries_d     = retries_q;
		ticks_d       = ticks_q;
		remain_d      = remain_q;
		pkt_len_d     = pkt_len_q;
		res.event_res = swpr_pkg::EV_NONE;
		res.data      = '0;
		res.length    = '0;
		if (mode == swpr_pkg::MODE_START) begin
			retries_d = cfg.retry_count;
			ticks_d   = '0;
			remain_d  = '0;
			phase_d   = PH_HUNT;
		end else if (phase_q != PH_IDLE && mode == swpr_pkg::MODE_TICK) begin
			ticks_d = ticks_inc;
			if (timeout) begin
				priority if (phase_q == PH_DATA) begin
					phase_d       = PH_IDLE;
					res.event_res = swpr_pkg::EV_DTMO;
				end else if (retries_q == '0) begin
					phase_d       = PH_IDLE;
					res.event_res = swpr_pkg::EV_NOPKT;
				end else begin
					retries_d = retries_q - 1'b1;
					ticks_d   = '0;
					phase_d   = PH_HUNT;
				end
			end
		end else if (phase_q != PH_IDLE && mode == swpr_pkg::MODE_BYTE) begin
			unique case (phase_q)
				PH_HUNT: begin
					ticks_d = '0;
					if (rx_byte == cfg.sync_word[swpr_pkg::SYNC_W-1 -: swpr_pkg::BYTE_W])
						phase_d = PH_SYNC2;
				end
				PH_SYNC2: begin
					phase_d = (rx_byte == cfg.sync_word[swpr_pkg::BYTE_W-1:0]) ? PH_LEN
						: PH_HUNT;
				end
				PH_LEN: begin
					priority if (rx_byte > cfg.max_length) begin
						phase_d = PH_HUNT;
					end else if (rx_byte == '0) begin
						pkt_len_d     = '0;
						phase_d       = PH_IDLE;
						res.event_res = swpr_pkg::EV_EMPTY;
					end else begin
						pkt_len_d = rx_byte;
						remain_d  = rx_byte;
						phase_d   = PH_DATA;
					end
				end
				PH_DATA: begin
					remain_d = remain_dec;
					res.data = rx_byte;
					if (remain_dec == '0) begin
						phase_d       = PH_IDLE;
						res.event_res = swpr_pkg::EV_LAST;
						res.length    = pkt_len_q;
					end else begin
						res.event_res = swpr_pkg::EV_BYTE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			retries_q <= '0;
			ticks_q   <= '0;
			remain_q  <= '0;
			pkt_len_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			retries_q <= retries_d;
			ticks_q   <= ticks_d;
			remain_q  <= remain_d;
			pkt_len_q <= pkt_len_d;
		end
	end

endmodule

@@ dv/swpr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swpr_checker
// Watches the request, result and register channels of the packet receiver,
// keeps its own deframer state, and compares every result with its forecast.
// ----------------------------------------------------------------------------
module swpr_checker
	import swpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic [1:0]            s_tuser,   // [1:0] mode
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [15:0]           m_tdata,   // [7:0] data, [15:8] length
	input  logic [2:0]            m_tuser,   // [2:0] event_res
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    results_due
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HUNT,
		ST_SYNC_LO,
		ST_LENGTH,
		ST_PAYLOAD
	} rx_state_t;

	cfg_t                regs;
	rx_state_t           rx_state;
	logic [RETRY_W-1:0]  retries_left;
	logic [PERIOD_W-1:0] ticks;
	logic [BYTE_W-1:0]   bytes_left;
	logic [BYTE_W-1:0]   pkt_len;
	res_t                forecast_q[$];

	// advances the deframer by one request and returns the event it reports
	function automatic res_t deframe_step(input mode_t mode, input logic [7:0] rx);
		res_t r;
		r.event_res = EV_NONE;
		r.data      = '0;
		r.length    = '0;
		if (mode == MODE_START) begin
			retries_left = regs.retry_count;
			ticks        = '0;
			bytes_left   = '0;
			rx_state     = ST_HUNT;
		end else if (rx_state != ST_IDLE && mode == MODE_TICK) begin
			ticks = ticks + 16'd1;
			if (ticks == regs.timeout_period) begin
				if (rx_state == ST_PAYLOAD) begin
					rx_state    = ST_IDLE;
					r.event_res = EV_DTMO;
				end else if (retries_left == '0) begin
					rx_state    = ST_IDLE;
					r.event_res = EV_NOPKT;
				end else begin
					retries_left = retries_left - 4'd1;
					ticks        = '0;
					rx_state     = ST_HUNT;
				end
			end
		end else if (rx_state != ST_IDLE && mode == MODE_BYTE) begin
			case (rx_state)
				ST_HUNT: begin
					ticks = '0;
					if (rx == regs.sync_word[15:8])
						rx_state = ST_SYNC_LO;
				end
				ST_SYNC_LO: begin
					rx_state = (rx == regs.sync_word[7:0]) ? ST_LENGTH : ST_HUNT;
				end
				ST_LENGTH: begin
					if (rx > regs.max_length) begin
						rx_state = ST_HUNT;
					end else if (rx == '0) begin
						pkt_len     = '0;
						rx_state    = ST_IDLE;
						r.event_res = EV_EMPTY;
					end else begin
						pkt_len    = rx;
						bytes_left = rx;
						rx_state   = ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					bytes_left = bytes_left - 8'd1;
					r.data     = rx;
					if (bytes_left == '0) begin
						rx_state    = ST_IDLE;
						r.event_res = EV_LAST;
						r.length    = pkt_len;
					end else begin
						r.event_res = EV_BYTE;
					end
				end
				default: rx_state = ST_IDLE;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			regs.max_length     = MAX_LENGTH_RST;
			regs.timeout_period = TIMEOUT_PERIOD_RST;
			regs.retry_count    = RETRY_COUNT_RST;
			regs.sync_word      = SYNC_WORD_RST;
			rx_state            = ST_IDLE;
			retries_left        = '0;
			ticks               = '0;
			bytes_left          = '0;
			pkt_len             = '0;
			forecast_q.delete();
			fail_count          = 0;
			results_due        <= 0;
		end else begin
			// compare before pushing so a result can never match its own request
			if (m_tvalid && m_tready) begin
				if (forecast_q.size() == 0) begin
					$error("result with no request waiting: event_res %0d", m_tuser);
					fail_count++;
				end else begin
					want = forecast_q.pop_front();
					if (m_tuser !== want.event_res) begin
						$error("event_res: expected %0d, got %0d", want.event_res, m_tuser);
						fail_count++;
					end
					if (m_tdata[7:0] !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, m_tdata[7:0]);
						fail_count++;
					end
					if (m_tdata[15:8] !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, m_tdata[15:8]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MAX_LENGTH:     regs.max_length     = cfg_data[BYTE_W-1:0];
					CFG_TIMEOUT_PERIOD: regs.timeout_period = cfg_data[PERIOD_W-1:0];
					CFG_RETRY_COUNT:    regs.retry_count    = cfg_data[RETRY_W-1:0];
					CFG_SYNC_WORD:      regs.sync_word      = cfg_data[SYNC_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				forecast_q.push_back(deframe_step(mode_t'(s_tuser), s_tdata));
			results_due <= forecast_q.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start commands, received bytes and timer ticks into the packet
// receiver under several register settings, with random gaps on both sides,
// a long result stall and long tick runs; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
	import swpr_pkg::*;

	localparam int ITEM_TARGET = 1450;
	localparam int TAIL_ITEMS  = 310;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic [1:0]            s_tuser = MODE_NONE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   fail_count;
	int   results_due;
	int   items_sent = 0;
	int   hold_token = 0;
	bit   quiet = 1'b0;
	cfg_t regs_now;

	sync_word_packet_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	swpr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(20_000_000);
		$display("** sync_word_packet_receiver: FAILED **");
		$finish;
	end

	// result side: random stalls, plus one long hold-off per token bump
	initial begin
		int seen;
		int n;
		seen = 0;
		forever begin
			@(posedge clk);
			if (hold_token != seen) begin
				seen = hold_token;
				m_tready <= 1'b0;
				for (n = 0; n < 96; n++)
					@(posedge clk);
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 10);
			end
		end
	end

	// valid stays high between back-to-back requests
	task automatic send_item(input mode_t mode, input logic [7:0] rx);
		while (!quiet && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(MODE_TICK, 8'($urandom));
	endtask

	// a frame byte, now and then preceded by a stray tick, unused mode or restart
	task automatic send_byte(input int rx);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			send_item(MODE_TICK, 8'($urandom));
		else if (r < 6)
			send_item(MODE_NONE, 8'($urandom));
		else if (r < 7)
			send_item(MODE_START, 8'($urandom));
		send_item(MODE_BYTE, 8'(rx));
	endtask

	task automatic load_regs(input cfg_t c);
		int k;
		cfg_idx_t idx;
		logic [CFG_DATA_W-1:0] val;
		for (k = 0; k < 4; k++) begin
			idx = cfg_idx_t'(k);
			case (idx)
				CFG_MAX_LENGTH:     val = {8'd0, c.max_length};
				CFG_TIMEOUT_PERIOD: val = c.timeout_period;
				CFG_RETRY_COUNT:    val = {12'd0, c.retry_count};
				default:            val = c.sync_word;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		regs_now = c;
	endtask

	// stop offering and wait until every result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_frame();
		int kind, n, r, len, cut, lim, span;
		logic [7:0] hi, lo, b;
		hi   = regs_now.sync_word[15:8];
		lo   = regs_now.sync_word[7:0];
		kind = $urandom_range(99);
		span = int'(regs_now.timeout_period) * (int'(regs_now.retry_count) + 1);
		send_item(MODE_START, 8'($urandom));
		// line noise while hunting, mostly bytes that cannot start a header
		n = $urandom_range(3);
		repeat (n) begin
			r = $urandom_range(9);
			if (r < 6) begin
				do b = 8'($urandom); while (b == hi);
				send_item(MODE_BYTE, b);
			end else if (r < 8) begin
				send_item(MODE_TICK, 8'($urandom));
			end else if (r < 9) begin
				send_item(MODE_NONE, 8'($urandom));
			end else begin
				send_item(MODE_BYTE, 8'($urandom));
			end
		end
		if (kind >= 96) begin
			// header timeouts until retries run out
			if (regs_now.timeout_period != 0 && span <= 600)
				send_ticks(span);
		end else begin
			send_byte(hi);
			if (kind >= 84) begin
				do b = 8'($urandom); while (b == lo);
				send_byte(b);
				send_byte(hi);
			end
			send_byte(lo);
			if (kind >= 72 && kind < 84 && regs_now.max_length != 8'd255) begin
				if ($urandom_range(1))
					send_byte(int'(regs_now.max_length) + 1);
				else
					send_byte($urandom_range(255, int'(regs_now.max_length) + 1));
				send_byte(hi);
				send_byte(lo);
			end
			r   = $urandom_range(99);
			lim = int'(regs_now.max_length);
			if (r < 88)
				len = $urandom_range(lim < 8 ? lim : 8);
			else if (r < 96)
				len = (lim <= 24) ? lim : $urandom_range(24);
			else
				len = $urandom_range(lim);
			send_byte(len);
			if (kind >= 60 && kind < 72 && len > 0) begin
				// payload cut short, then ticks until the data timeout
				cut = $urandom_range(len - 1);
				repeat (cut) send_byte($urandom_range(255));
				if (regs_now.timeout_period != 0 && regs_now.timeout_period <= 600)
					send_ticks(int'(regs_now.timeout_period));
			end else begin
				repeat (len) send_byte($urandom_range(255));
			end
		end
	endtask

	initial begin
		int phase_no, r;
		cfg_t c;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: idle inputs ignored, a short packet, an empty packet
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_BYTE, 8'hC0);
		send_item(MODE_NONE, 8'hFF);
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'hC0);
		send_item(MODE_BYTE, 8'hDE);
		send_item(MODE_NONE, 8'h5A);
		send_item(MODE_BYTE, 8'h02);
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_START, 8'hFF);
		send_item(MODE_BYTE, 8'hC0);
		send_item(MODE_BYTE, 8'h11);
		send_item(MODE_BYTE, 8'hC0);
		send_item(MODE_BYTE, 8'hDE);
		send_item(MODE_BYTE, 8'h00);
		drain();

		// short timeouts: too long, header retry then no packet, length timeout,
		// payload timeout
		c = '{max_length: 8'd4, timeout_period: 16'd2, retry_count: 4'd1,
			sync_word: 16'h0000};
		load_regs(c);
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h05);
		send_item(MODE_BYTE, 8'h00);
		send_ticks(4);
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_ticks(2);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h04);
		send_item(MODE_BYTE, 8'h80);
		send_ticks(2);
		drain();

		phase_no = 0;
		while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
			if (phase_no == 0) begin
				c = '{max_length: 8'd0, timeout_period: 16'd1, retry_count: 4'd15,
					sync_word: 16'hFFFF};
			end else begin
				r = $urandom_range(9);
				c.max_length = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
					(r == 2) ? 8'($urandom) : 8'($urandom_range(1, 40));
				r = $urandom_range(9);
				c.timeout_period = (r == 0) ? 16'd1 : (r < 7) ? 16'($urandom_range(2, 16)) :
					(r < 9) ? 16'($urandom_range(17, 300)) : 16'($urandom);
				c.retry_count = 4'($urandom_range(15));
				r = $urandom_range(9);
				b_sync: begin
					logic [7:0] x;
					x = 8'($urandom);
					c.sync_word = (r < 7) ? 16'($urandom) : (r == 7) ? SYNC_WORD_RST :
						(r == 8) ? {16{x[0]}} : {x, x};
				end
			end
			quiet = (phase_no == 2);
			load_regs(c);
			if (phase_no == 1)
				hold_token++;
			repeat ($urandom_range(6, 14)) send_frame();
			drain();
			phase_no++;
		end

		// zero period: the count wraps, so no timeout within a few hundred ticks
		quiet = 1'b1;
		c = '{max_length: 8'd255, timeout_period: 16'd0, retry_count: 4'd0,
			sync_word: SYNC_WORD_RST};
		load_regs(c);
		send_item(MODE_START, 8'h00);
		send_ticks(200);
		drain();

		// longest period: a long tick run inside a payload does not cut it short
		c.timeout_period = 16'hFFFF;
		load_regs(c);
		send_item(MODE_START, 8'h00);
		send_item(MODE_BYTE, 8'hC0);
		send_item(MODE_BYTE, 8'hDE);
		send_item(MODE_BYTE, 8'h02);
		send_item(MODE_BYTE, 8'h3C);
		send_ticks(100);
		send_item(MODE_BYTE, 8'hA5);
		drain();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("** sync_word_packet_receiver: PASSED **");
		else
			$display("** sync_word_packet_receiver: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
design/swpr_pkg.sv
design/swpr_core.sv
design/sync_word_packet_receiver.sv
dv/swpr_checker.sv
dv/testbench.sv
